/* design/cbef_pkg.sv */
package cbef_pkg;

  localparam int FRAME_ID_W  = 29;
  localparam int ID_BITS     = 29;
  localparam int LEARN_DEPTH = 64;
  localparam int TYPE_DEPTH  = 64;
  localparam int FUNC_W      = 2;

  typedef logic [ID_BITS-1:0]    id_t;
  typedef logic [FRAME_ID_W-1:0] frame_id_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_HW     = 2'd0,
    FUNC_VIRT   = 2'd1,
    FUNC_DEFINE = 2'd2
  } func_t;

  typedef struct packed {
    logic hit;
    logic full;
  } learn_status_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic fd;
  } type_status_t;

  typedef struct packed {
    logic      forward;
    logic      to_hardware;
    logic      send_fd;
    frame_id_t out_id;
    logic      id_defined;
    logic      table_overflow;
  } result_t;

  typedef struct packed {
    logic learn_heard;
    logic learn_sent;
    logic define_en;
  } update_t;

endpackage

/* design/cbef_learn_cam.sv */
module cbef_learn_cam (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cbef_pkg::id_t          lookup_id,
  input  logic                   learn_en,
  output cbef_pkg::learn_status_t status
);
  import cbef_pkg::*;

  typedef logic [LEARN_DEPTH-1:0] learn_mask_t;

  id_t         ids_r [LEARN_DEPTH];
  learn_mask_t valid_r;
  learn_mask_t valid_nxt;
  learn_mask_t match;
  learn_mask_t free;
  learn_mask_t free_oh;
  logic        do_write;

  always_comb begin
    for (int i = 0; i < LEARN_DEPTH; i++) begin
      match[i] = valid_r[i] && (ids_r[i] == lookup_id);
    end
  end

  // isolate the lowest free entry
  assign free        = ~valid_r;
  assign free_oh     = free & (~free + learn_mask_t'(1));
  assign status.hit  = |match;
  assign status.full = &valid_r;
  assign do_write    = learn_en && !status.hit;
  assign valid_nxt   = do_write ? (valid_r | free_oh) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LEARN_DEPTH; i++) begin
      if (do_write && free_oh[i]) begin
        ids_r[i] <= lookup_id;
      end
    end
  end

endmodule

/* design/cbef_type_cam.sv */
module cbef_type_cam (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cbef_pkg::id_t         lookup_id,
  input  logic                  define_en,
  input  logic                  define_fd,
  output cbef_pkg::type_status_t status
);
  import cbef_pkg::*;

  typedef logic [TYPE_DEPTH-1:0] type_mask_t;

  id_t        ids_r [TYPE_DEPTH];
  type_mask_t fd_r;
  type_mask_t valid_r;
  type_mask_t valid_nxt;
  type_mask_t match;
  type_mask_t free;
  type_mask_t free_oh;
  logic       do_insert;

  always_comb begin
    for (int i = 0; i < TYPE_DEPTH; i++) begin
      match[i] = valid_r[i] && (ids_r[i] == lookup_id);
    end
  end

  assign free        = ~valid_r;
  assign free_oh     = free & (~free + type_mask_t'(1));
  assign status.hit  = |match;
  assign status.full = &valid_r;
  // entries hold unique IDs, so at most one match bit is set
  assign status.fd   = |(match & fd_r);
  assign do_insert   = define_en && !status.hit;
  assign valid_nxt   = do_insert ? (valid_r | free_oh) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TYPE_DEPTH; i++) begin
      if (define_en && status.hit && match[i]) begin
        fd_r[i] <= define_fd;
      end else if (do_insert && free_oh[i]) begin
        fd_r[i]  <= define_fd;
        ids_r[i] <= lookup_id;
      end
    end
  end

endmodule

/* design/cbef_decide.sv */
module cbef_decide (
  input  logic                   fire,
  input  logic                   powered,
  input  cbef_pkg::func_t        func,
  input  cbef_pkg::id_t          id,
  input  cbef_pkg::learn_status_t heard,
  input  cbef_pkg::learn_status_t sent,
  input  cbef_pkg::type_status_t  ftype,
  output cbef_pkg::result_t      result,
  output cbef_pkg::update_t      update
);
  import cbef_pkg::*;

  logic fwd;

  always_comb begin
    result = '0;
    update = '0;
    fwd    = 1'b0;
    unique case (func)
      FUNC_HW: begin
        fwd                   = powered && !sent.hit;
        result.forward        = fwd;
        result.out_id         = fwd ? frame_id_t'(id) : '0;
        result.table_overflow = fwd && heard.full && !heard.hit;
        update.learn_heard    = fire && fwd;
      end
      FUNC_VIRT: begin
        fwd                   = powered && !heard.hit;
        result.forward        = fwd;
        result.to_hardware    = fwd;
        result.send_fd        = fwd && (ftype.hit ? ftype.fd : 1'b1);
        result.out_id         = fwd ? frame_id_t'(id) : '0;
        result.id_defined     = fwd && ftype.hit;
        result.table_overflow = fwd && sent.full && !sent.hit;
        update.learn_sent     = fire && fwd;
      end
      FUNC_DEFINE: begin
        result.id_defined     = ftype.hit;
        result.table_overflow = !ftype.hit && ftype.full;
        update.define_en      = fire;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

/* design/can_bridge_echo_filter_unit.sv */
// CAN gateway echo filter. Each beat on the in_ channel is a frame from the
// hardware bus (in_func 0), a frame from the virtual bus (1) or a frame-type
// definition (2); every beat yields exactly one result beat on the out_
// channel. Hardware frames are forwarded to the virtual bus unless their ID
// was earlier sent toward hardware, and a forwarded ID is learned as heard;
// virtual frames go to hardware unless their ID was heard, a forwarded ID is
// learned as sent, and send_fd comes from the type table (FD when the ID is
// undefined). While cfg_powered is written zero every frame is dropped;
// definitions still apply. Learned sets and the type table are 64-entry CAMs
// in flip-flops that only reset clears; a full set keeps forwarding and
// raises table_overflow. Throughput is one beat per clock unless out_stall
// holds the result register; an input register is followed by the result
// register, with the parallel CAM compare and insert done between them.
// cfg_ready is always high; write the power register only while the block is idle.
module can_bridge_echo_filter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cbef_pkg::FUNC_W-1:0]   in_func,
  input  logic [cbef_pkg::FRAME_ID_W-1:0] in_frame_id,
  input  logic                          in_define_fd,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_forward,
  output logic                          out_to_hardware,
  output logic                          out_send_fd,
  output logic [cbef_pkg::FRAME_ID_W-1:0] out_id,
  output logic                          out_id_defined,
  output logic                          out_table_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_powered
);
  import cbef_pkg::*;

  // input stage
  logic    s1_valid_r;
  func_t   s1_func_r;
  id_t     s1_id_r;
  logic    s1_dfd_r;

  // result stage
  logic    out_valid_r;
  result_t res_r;

  logic    powered_r;

  logic          out_free;
  logic          fire;
  logic          in_take;
  learn_status_t heard_st;
  learn_status_t sent_st;
  type_status_t  type_st;
  result_t       res_nxt;
  update_t       upd;

  // the result register frees up when empty or when its beat is taken
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r <= 1'b0;
    end else if (cfg_valid) begin
      powered_r <= cfg_powered;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold while stalled, advance otherwise; ID_BITS equals the frame ID width, so the whole ID is kept
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= func_t'(in_func);
      s1_id_r   <= in_frame_id[ID_BITS-1:0];
      s1_dfd_r  <= in_define_fd;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  // CAM writes land on the same edge the item moves to the result register,
  // so the next item in the input stage already sees them
  cbef_learn_cam u_heard (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_id (s1_id_r),
    .learn_en  (upd.learn_heard),
    .status    (heard_st)
  );

  cbef_learn_cam u_sent (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_id (s1_id_r),
    .learn_en  (upd.learn_sent),
    .status    (sent_st)
  );

  cbef_type_cam u_type (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_id (s1_id_r),
    .define_en (upd.define_en),
    .define_fd (s1_dfd_r),
    .status    (type_st)
  );

  cbef_decide u_decide (
    .fire    (fire),
    .powered (powered_r),
    .func    (s1_func_r),
    .id      (s1_id_r),
    .heard   (heard_st),
    .sent    (sent_st),
    .ftype   (type_st),
    .result  (res_nxt),
    .update  (upd)
  );

  assign out_valid          = out_valid_r;
  assign out_forward        = res_r.forward;
  assign out_to_hardware    = res_r.to_hardware;
  assign out_send_fd        = res_r.send_fd;
  assign out_id             = res_r.out_id;
  assign out_id_defined     = res_r.id_defined;
  assign out_table_overflow = res_r.table_overflow;

endmodule
